[design/suffix_trie_shortest_match_core_macros.svh]
// Assertion macros for the checker file of the suffix trie core.
// Each macro expands to one labeled concurrent assertion, clocked on clk
// and disabled while rst_n is low.
`ifndef SUFFIX_TRIE_SHORTEST_MATCH_CORE_MACROS_SVH
`define SUFFIX_TRIE_SHORTEST_MATCH_CORE_MACROS_SVH

// Same-cycle implication.
`define STSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/stsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_pkg
// Types and constants shared by the suffix trie shortest-match core.
// ----------------------------------------------------------------------------
package stsm_pkg;

  // Default sizing
  localparam int NODES_DEF    = 4096;
  localparam int ALPHABET_DEF = 26;

  // Fixed field widths
  localparam int LETTER_W = 5;
  localparam int LEN_W    = 11;
  localparam int IDX_W    = 16;
  localparam int BEST_W   = 17;

  // Sentinel values
  localparam logic [LEN_W-1:0]  LEN_MAX   = '1;   // longest length, never beaten
  localparam logic [BEST_W-1:0] BEST_NONE = '1;   // -1, no word recorded

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [LETTER_W-1:0] letter;
    logic                first_letter;
    logic                last_letter;
    logic [LEN_W-1:0]    word_len;
    logic [IDX_W-1:0]    word_index;
  } in_item_t;

  typedef struct packed {
    logic signed [BEST_W-1:0] best_index;
    logic                     pool_full;
    logic                     was_query;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic clr;      // write one zero entry of the clearing pass
    logic load;     // take the input item, issue the link read
    logic commit;   // apply the update, write back, post result
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_done;     // clearing pass at its last entry
    logic item_last;    // held item ends a word
    logic out_blocked;  // output register full and stalled
  } dp_status_t;

endpackage

[design/suffix_trie_shortest_match_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_trie_shortest_match_core
// Suffix trie fed one letter per transfer; answers shortest-word queries.
// ----------------------------------------------------------------------------
// Each input transfer reads the child-link entry of the current node, then
// updates the walk and writes the entry back through the link memory's
// single read and write port; no new transfer is taken until the last is
// done. A word end whose result finds the output register full and stalled
// waits there. After reset the block clears its link memory, one entry per
// cycle, over all NODES*ALPHABET entries (106496 at defaults), with in_stall
// high meanwhile. Results appear only for transfers with last_letter set.
module suffix_trie_shortest_match_core #(
  parameter int NODES    = stsm_pkg::NODES_DEF,
  parameter int ALPHABET = stsm_pkg::ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stsm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stsm_pkg::out_item_t out_data
);

  stsm_pkg::ctrl_cmd_t  cmd;
  stsm_pkg::dp_status_t status;

  stsm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  stsm_dp #(
    .NODES   (NODES),
    .ALPHABET(ALPHABET)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[design/stsm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/stsm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_ctrl
// Sequencer: clearing pass after reset, then load / execute per item.
// ----------------------------------------------------------------------------
module stsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stsm_pkg::dp_status_t status,
  output stsm_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a word end waits for room in the output register
        if (!(status.item_last && status.out_blocked)) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

[design/stsm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_dp
// Datapath: walk registers, root node, link memory and output register.
// Each link entry holds the child node plus that child's shortest length
// and best index, so one read and one write cover a letter.
// ----------------------------------------------------------------------------
module stsm_dp #(
  parameter int NODES    = stsm_pkg::NODES_DEF,
  parameter int ALPHABET = stsm_pkg::ALPHABET_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stsm_pkg::in_item_t   in_data,
  input  stsm_pkg::ctrl_cmd_t  cmd,
  output stsm_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stsm_pkg::out_item_t  out_data
);

  localparam int NODE_W = $clog2(NODES);
  localparam int NF_W   = $clog2(NODES + 1);
  localparam int DEPTH  = NODES * ALPHABET;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = stsm_pkg::LEN_W;
  localparam int BEST_W = stsm_pkg::BEST_W;
  localparam int ENT_W  = NODE_W + LEN_W + BEST_W;

  // walk and pool state
  logic [NODE_W-1:0] cursor_r, cursor_nxt;
  logic              stopped_r, stopped_nxt;
  logic [BEST_W-1:0] running_r, running_nxt;
  logic [NF_W-1:0]   next_free_r, next_free_nxt;
  logic [LEN_W-1:0]  root_min_r;
  logic [BEST_W-1:0] root_best_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              out_valid_r;

  // payload registers
  stsm_pkg::in_item_t  item_r;
  logic [ADDR_W-1:0]   addr_r;
  stsm_pkg::out_item_t out_data_r, res;

  // memory signals
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0]  rd_data, wr_data, upd_data;
  logic              wr_en, upd_we;

  // load-side address
  logic [NODE_W-1:0] cur_eff;
  logic [ADDR_W-1:0] let_in;

  // execute-side decode
  logic [NODE_W-1:0] rd_link;
  logic [LEN_W-1:0]  rd_min;
  logic [BEST_W-1:0] rd_best;
  logic              hit, letter_ok, pool_out, len_fits;
  logic [BEST_W-1:0] idx_ext;

  // slot address of the letter under the (possibly restarted) cursor
  always_comb begin
    cur_eff = in_data.first_letter ? '0 : cursor_r;
    let_in  = (32'(in_data.letter) < ALPHABET) ? ADDR_W'(in_data.letter) : '0;
    rd_addr = ADDR_W'(cur_eff) * ADDR_W'(ALPHABET) + let_in;
  end

  // decode the entry read for the held item
  assign rd_link   = rd_data[ENT_W-1 -: NODE_W];
  assign rd_min    = rd_data[BEST_W +: LEN_W];
  assign rd_best   = rd_data[BEST_W-1:0];
  assign hit       = (rd_link != '0) && (32'(rd_link) < NODES);
  assign letter_ok = 32'(item_r.letter) < ALPHABET;
  assign pool_out  = next_free_r >= NF_W'(NODES);
  assign len_fits  = item_r.word_len < stsm_pkg::LEN_MAX;
  assign idx_ext   = {1'b0, item_r.word_index};

  // one letter step: follow, allocate or stop
  always_comb begin
    cursor_nxt    = cursor_r;
    stopped_nxt   = stopped_r;
    running_nxt   = running_r;
    next_free_nxt = next_free_r;
    upd_we        = 1'b0;
    upd_data      = rd_data;
    if (!stopped_r) begin
      if (item_r.req_type == stsm_pkg::REQ_QUERY) begin
        if (!letter_ok || !hit) begin
          stopped_nxt = 1'b1;
        end else begin
          cursor_nxt  = rd_link;
          running_nxt = rd_best;
        end
      end else if (letter_ok) begin
        if (hit) begin
          cursor_nxt = rd_link;
          if (item_r.word_len < rd_min) begin
            upd_we   = 1'b1;
            upd_data = {rd_link, item_r.word_len, idx_ext};
          end
        end else if (pool_out) begin
          stopped_nxt = 1'b1;
        end else begin
          // fresh node starts at the maximum, then takes this word if shorter
          upd_we        = 1'b1;
          cursor_nxt    = NODE_W'(next_free_r);
          next_free_nxt = next_free_r + NF_W'(1);
          upd_data      = {NODE_W'(next_free_r),
                           len_fits ? item_r.word_len : stsm_pkg::LEN_MAX,
                           len_fits ? idx_ext : stsm_pkg::BEST_NONE};
        end
      end
    end
  end

  // result of a word end
  always_comb begin
    res = '0;
    if (item_r.req_type == stsm_pkg::REQ_QUERY) begin
      res.best_index = running_nxt;
      res.was_query  = 1'b1;
    end else begin
      res.pool_full  = stopped_nxt;
    end
  end

  // memory port muxing: clearing pass or write-back
  assign wr_en   = cmd.clr | (cmd.commit & upd_we);
  assign wr_addr = cmd.clr ? clr_cnt_r : addr_r;
  assign wr_data = cmd.clr ? '0 : upd_data;

  stsm_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_link_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (cmd.load),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      stopped_r   <= 1'b0;
      running_r   <= stsm_pkg::BEST_NONE;
      next_free_r <= NF_W'(1);
      root_min_r  <= stsm_pkg::LEN_MAX;
      root_best_r <= stsm_pkg::BEST_NONE;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      // word start: back to the root, root records an inserted word if shorter
      if (cmd.load && in_data.first_letter) begin
        cursor_r  <= '0;
        stopped_r <= 1'b0;
        running_r <= root_best_r;
        if (in_data.req_type == stsm_pkg::REQ_INSERT && in_data.word_len < root_min_r) begin
          root_min_r  <= in_data.word_len;
          root_best_r <= {1'b0, in_data.word_index};
        end
      end
      if (cmd.commit) begin
        cursor_r    <= cursor_nxt;
        stopped_r   <= stopped_nxt;
        running_r   <= running_nxt;
        next_free_r <= next_free_nxt;
      end
      // output register: a new result replaces one taken this cycle
      if (cmd.commit && item_r.last_letter) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      addr_r <= rd_addr;
    end
    if (cmd.commit && item_r.last_letter) begin
      out_data_r <= res;
    end
  end

  assign status.clr_done    = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign status.item_last   = item_r.last_letter;
  assign status.out_blocked = out_valid_r & out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/stsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsm_checker
// Port-level checks of the suffix trie core, bound to the top level.
// ----------------------------------------------------------------------------
`include "suffix_trie_shortest_match_core_macros.svh"

module stsm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input stsm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input stsm_pkg::out_item_t out_data
);

  // stalled result holds
  `STSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // one item at a time: an accepted transfer blocks the next cycle
  `STSM_ASSERT_NEXT(a_in_one_at_a_time, in_valid && !in_stall, in_stall, "back-to-back input accepted")

  // queries never report pool exhaustion
  `STSM_ASSERT_SAME(a_query_no_full, out_valid && out_data.was_query, !out_data.pool_full, "query result flagged pool_full")

  // insert results carry a zero index
  `STSM_ASSERT_SAME(a_insert_zero_idx, out_valid && !out_data.was_query, out_data.best_index == '0, "insert result has nonzero index")

endmodule

bind suffix_trie_shortest_match_core stsm_checker u_stsm_checker (.*);
